// ===== rtl/dvst_pkg.sv =====
// Package for the voltage level table: widths, reset values, register indexes,
// result codes and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package dvst_pkg;

   // Field and register widths.
   localparam int UV_W       = 22;
   localparam int FINE_W     = 17;
   localparam int COARSE_W   = 18;
   localparam int CODE_W     = 7;
   localparam int COUNT_W    = 5;
   localparam int LEVEL_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int VOUT_W     = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   // Readback voltage width: a 25-bit product plus a 22-bit base.
   localparam int PROD_W = CODE_W + COARSE_W;
   localparam int VSUM_W = PROD_W + 1;

   // Table size default.
   localparam int LEVELS_DEFAULT = 16;

   // Divider: one quotient bit per cycle over the whole numerator.
   localparam int DIV_STEPS = UV_W;
   localparam int DIV_CNT_W = 5;

   // Largest code the regulator takes.
   localparam logic [CODE_W-1:0] CODE_MAX = 7'h7f;

   // Register reset values.
   localparam logic [UV_W-1:0]     MIN_UV_RST      = 22'd600000;
   localparam logic [UV_W-1:0]     MID_UV_RST      = 22'd1600000;
   localparam logic [UV_W-1:0]     MAX_UV_RST      = 22'd1800000;
   localparam logic [FINE_W-1:0]   FINE_STEP_RST   = 17'd12500;
   localparam logic [COARSE_W-1:0] COARSE_STEP_RST = 18'd50000;
   localparam logic [CODE_W-1:0]   MID_CODE_RST    = 7'h50;
   localparam logic [COUNT_W-1:0]  LEVEL_COUNT_RST = 5'd16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MIN_UV      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MID_UV      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_UV      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FINE_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COARSE_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MID_CODE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_COUNT = 3'd6;

   // Request kinds.
   localparam logic REQ_SET = 1'b0;
   localparam logic REQ_GET = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_LEVEL_BAD   = 2'd1,
      STATUS_REQ_VOLT    = 2'd2,
      STATUS_STORED_VOLT = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic start_div;
      logic div_step;
      logic write_code;
      logic rd_en;
      logic load_code;
      logic mul;
      logic add;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_get;
      logic volt_bad;
      logic level_bad;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/dvst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module dvst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/dvst_ctrl.sv =====
// Controller for the voltage level table: sequences checks, division, table
// access, readback arithmetic and the result register. Uses dvst_pkg.
`default_nettype none

module dvst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire dvst_pkg::stat_type stat,
   output dvst_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_WRITE,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   localparam logic [dvst_pkg::DIV_CNT_W-1:0] DIV_LAST =
      dvst_pkg::DIV_CNT_W'(dvst_pkg::DIV_STEPS - 1);

   state_type                         state_ff, state_in;
   logic [dvst_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_free;

   // The result slot can take a new item when empty or being emptied.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_get == dvst_pkg::REQ_SET) begin
               if (stat.volt_bad || stat.level_bad) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.start_div = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_DIV;
               end
            end else if (stat.level_bad) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_code = 1'b1;
            state_in       = ST_DONE;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_code = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set when an item is loaded, cleared when it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a stalled item");

   // An accepted item always goes on to the check step.
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CHECK))
      else $error("accepted item did not reach the check step");

   // The divider never runs past its last step.
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count overran");

   // The table is written only by a good set.
   a_write_set: assert property (@(posedge clock) disable iff (reset)
      cmd.write_code |-> (stat.is_get == dvst_pkg::REQ_SET) && !stat.level_bad
                         && !stat.volt_bad)
      else $error("table written by a request that is not a good set");

endmodule

`default_nettype wire

// ===== rtl/dvst_dp.sv =====
// Datapath for the voltage level table: configuration registers, request
// latch, restoring divider, code table, readback arithmetic and result register.
// Uses dvst_pkg and dvst_ram.
`default_nettype none

module dvst_dp #(
   parameter int LEVELS = dvst_pkg::LEVELS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [dvst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dvst_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  wire logic                                req_type,
   input  wire logic [dvst_pkg::LEVEL_W-1:0]        req_level,
   input  wire logic [dvst_pkg::UV_W-1:0]           req_target_microvolts,
   output logic      [dvst_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [dvst_pkg::VOUT_W-1:0]         rsp_voltage_uv,
   output logic      [dvst_pkg::CODE_W-1:0]         rsp_voltage_code,
   input  wire dvst_pkg::cmd_type                   cmd,
   output dvst_pkg::stat_type                       stat
);

   localparam int IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LEXT_W = 7;
   localparam logic [LEXT_W-1:0] LEVELS_V = LEXT_W'(LEVELS);

   // Configuration registers.
   logic [dvst_pkg::UV_W-1:0]     min_uv_ff, mid_uv_ff, max_uv_ff;
   logic [dvst_pkg::FINE_W-1:0]   fine_step_ff;
   logic [dvst_pkg::COARSE_W-1:0] coarse_step_ff;
   logic [dvst_pkg::CODE_W-1:0]   mid_code_ff;
   logic [dvst_pkg::COUNT_W-1:0]  level_count_ff;

   // Request latch.
   logic                          is_get_ff;
   logic [dvst_pkg::LEVEL_W-1:0]  level_ff;
   logic [dvst_pkg::UV_W-1:0]     uv_ff;

   // Divider and readback registers.
   logic [dvst_pkg::COARSE_W-1:0] rem_ff, rem_in, den_ff;
   logic [dvst_pkg::UV_W-1:0]     quo_ff, quo_in;
   logic                          upper_ff;
   logic [dvst_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [dvst_pkg::CODE_W-1:0]   fac_ff;
   logic [dvst_pkg::PROD_W-1:0]   prod_ff;
   logic [dvst_pkg::VSUM_W-1:0]   volt_ff;
   logic [LEVELS-1:0]             valid_ff;

   // Result register.
   logic [dvst_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [dvst_pkg::VOUT_W-1:0]   vout_ff, vout_in;
   logic [dvst_pkg::CODE_W-1:0]   rcode_ff, rcode_in;

   logic [LEXT_W-1:0]             level_ext;
   logic [IDX_W-1:0]              addr;
   logic                          volt_bad, level_bad, stored_bad;
   logic                          seg_upper;
   logic [dvst_pkg::UV_W-1:0]     div_num;
   logic [dvst_pkg::COARSE_W-1:0] div_den;
   logic [dvst_pkg::COARSE_W:0]   trial, trial_sub;
   logic                          trial_ge;
   logic [dvst_pkg::UV_W:0]       code_sum;
   logic [dvst_pkg::CODE_W-1:0]   rd_code, stored_code;
   logic                          rd_upper;
   logic [dvst_pkg::COARSE_W-1:0] mul_step;
   logic [dvst_pkg::UV_W-1:0]     add_base;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_uv_ff      <= dvst_pkg::MIN_UV_RST;
         mid_uv_ff      <= dvst_pkg::MID_UV_RST;
         max_uv_ff      <= dvst_pkg::MAX_UV_RST;
         fine_step_ff   <= dvst_pkg::FINE_STEP_RST;
         coarse_step_ff <= dvst_pkg::COARSE_STEP_RST;
         mid_code_ff    <= dvst_pkg::MID_CODE_RST;
         level_count_ff <= dvst_pkg::LEVEL_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            dvst_pkg::REG_MIN_UV:      min_uv_ff      <= csr_wr_data;
            dvst_pkg::REG_MID_UV:      mid_uv_ff      <= csr_wr_data;
            dvst_pkg::REG_MAX_UV:      max_uv_ff      <= csr_wr_data;
            dvst_pkg::REG_FINE_STEP:   fine_step_ff   <= csr_wr_data[dvst_pkg::FINE_W-1:0];
            dvst_pkg::REG_COARSE_STEP: coarse_step_ff <= csr_wr_data[dvst_pkg::COARSE_W-1:0];
            dvst_pkg::REG_MID_CODE:    mid_code_ff    <= csr_wr_data[dvst_pkg::CODE_W-1:0];
            dvst_pkg::REG_LEVEL_COUNT: level_count_ff <= csr_wr_data[dvst_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Range checks on the latched request.
   assign level_ext = {3'b000, level_ff};
   assign addr      = level_ext[IDX_W-1:0];
   assign volt_bad  = (uv_ff < min_uv_ff) || (uv_ff > max_uv_ff);
   assign level_bad = ({1'b0, level_ff} >= level_count_ff) || (level_ext >= LEVELS_V);

   assign stat.is_get    = is_get_ff;
   assign stat.volt_bad  = volt_bad;
   assign stat.level_bad = level_bad;

   // Segment choice and divider operands for a set.
   assign seg_upper = (uv_ff >= mid_uv_ff);
   assign div_num   = seg_upper ? (uv_ff - mid_uv_ff) : (uv_ff - min_uv_ff);
   assign div_den   = seg_upper ? coarse_step_ff : {1'b0, fine_step_ff};

   // One restoring division step: shift in the next numerator bit.
   assign trial     = {rem_ff, quo_ff[dvst_pkg::UV_W-1]};
   assign trial_ge  = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};
   assign rem_in    = trial_ge ? trial_sub[dvst_pkg::COARSE_W-1:0]
                               : trial[dvst_pkg::COARSE_W-1:0];
   assign quo_in    = {quo_ff[dvst_pkg::UV_W-2:0], trial_ge};

   // Code from the quotient, with the coarse offset and saturation.
   assign code_sum = {1'b0, quo_ff} +
                     (upper_ff ? (dvst_pkg::UV_W+1)'(mid_code_ff) : '0);

   always_comb begin
      if ((den_ff == '0) || (code_sum > (dvst_pkg::UV_W+1)'(dvst_pkg::CODE_MAX))) begin
         code_in = dvst_pkg::CODE_MAX;
      end else begin
         code_in = code_sum[dvst_pkg::CODE_W-1:0];
      end
   end

   // Code table; an entry never written reads as zero.
   dvst_ram #(
      .WIDTH (dvst_pkg::CODE_W),
      .DEPTH (LEVELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_code),
      .wr_addr (addr),
      .wr_data (code_in),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (rd_code)
   );

   assign stored_code = valid_ff[addr] ? rd_code : '0;
   assign rd_upper    = (stored_code >= mid_code_ff);

   // Readback operands follow the segment of the stored code.
   assign mul_step = upper_ff ? coarse_step_ff : {1'b0, fine_step_ff};
   assign add_base = upper_ff ? mid_uv_ff : min_uv_ff;

   // Entry valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_code) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // Request latch, divider and readback arithmetic.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_get_ff <= req_type;
         level_ff  <= req_level;
         uv_ff     <= req_target_microvolts;
      end
      if (cmd.start_div) begin
         rem_ff   <= '0;
         quo_ff   <= div_num;
         den_ff   <= div_den;
         upper_ff <= seg_upper;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.write_code) begin
         code_ff <= code_in;
      end
      if (cmd.load_code) begin
         code_ff  <= stored_code;
         upper_ff <= rd_upper;
         fac_ff   <= rd_upper ? (stored_code - mid_code_ff) : stored_code;
      end
      if (cmd.mul) begin
         prod_ff <= {{dvst_pkg::COARSE_W{1'b0}}, fac_ff} *
                    {{dvst_pkg::CODE_W{1'b0}}, mul_step};
      end
      if (cmd.add) begin
         volt_ff <= {1'b0, prod_ff} + dvst_pkg::VSUM_W'(add_base);
      end
   end

   // Result selection.
   assign stored_bad = (volt_ff < dvst_pkg::VSUM_W'(min_uv_ff)) ||
                       (volt_ff > dvst_pkg::VSUM_W'(max_uv_ff));

   always_comb begin
      status_in = dvst_pkg::STATUS_OK;
      vout_in   = '0;
      rcode_in  = '0;
      if (is_get_ff == dvst_pkg::REQ_SET) begin
         if (volt_bad) begin
            status_in = dvst_pkg::STATUS_REQ_VOLT;
         end else if (level_bad) begin
            status_in = dvst_pkg::STATUS_LEVEL_BAD;
         end else begin
            rcode_in = code_ff;
         end
      end else if (level_bad) begin
         status_in = dvst_pkg::STATUS_LEVEL_BAD;
      end else if (stored_bad) begin
         status_in = dvst_pkg::STATUS_STORED_VOLT;
         vout_in   = dvst_pkg::VOUT_W'(min_uv_ff);
         rcode_in  = code_ff;
      end else begin
         vout_in  = volt_ff[dvst_pkg::VOUT_W-1:0];
         rcode_in = code_ff;
      end
   end

   // Result register, loaded only when the output slot is free.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= status_in;
         vout_ff   <= vout_in;
         rcode_ff  <= rcode_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_voltage_uv   = vout_ff;
   assign rsp_voltage_code = rcode_ff;

endmodule

`default_nettype wire

// ===== rtl/dvc_voltage_set_table_top.sv =====
// Top level of the dynamic-voltage-change level table.
// Depends on dvst_pkg, dvst_ctrl and dvst_dp.
//
//   Channel   Direction   Handshake              Carries
//   req_      in          req_valid/req_stall    req_type, req_level, req_target_microvolts
//   rsp_      out         rsp_valid/rsp_stall    rsp_status, rsp_voltage_uv, rsp_voltage_code
//   csr_      in          csr_wr_en              csr_index, csr_wr_data
//
// One item is worked on at a time. A good set passes the check step, the restoring
// divider, which makes one quotient bit per cycle over 22 bits, and a table write before
// its result is loaded. A good get passes one table read, one multiply and one add, and a
// rejected request goes from the check step straight to the result. Reset is synchronous;
// the table reads as code zero until written. A new item is taken
// while an earlier result still waits on rsp_stall; it then holds in its last step.
`default_nettype none

module dvc_voltage_set_table_top #(
   parameter int LEVELS = dvst_pkg::LEVELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [dvst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dvst_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_type,
   input  wire logic [dvst_pkg::LEVEL_W-1:0]    req_level,
   input  wire logic [dvst_pkg::UV_W-1:0]       req_target_microvolts,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [dvst_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [dvst_pkg::VOUT_W-1:0]     rsp_voltage_uv,
   output logic      [dvst_pkg::CODE_W-1:0]     rsp_voltage_code
);

   dvst_pkg::cmd_type  cmd;
   dvst_pkg::stat_type stat;

   // Sequencing of each item.
   dvst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Registers, table and arithmetic.
   dvst_dp #(
      .LEVELS (LEVELS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_type              (req_type),
      .req_level             (req_level),
      .req_target_microvolts (req_target_microvolts),
      .rsp_status            (rsp_status),
      .rsp_voltage_uv        (rsp_voltage_uv),
      .rsp_voltage_code      (rsp_voltage_code),
      .cmd                   (cmd),
      .stat                  (stat)
   );

endmodule

`default_nettype wire

// ===== sim/dvst_level_checker.sv =====
// Checker for the voltage level table: watches the register port and both item channels,
// predicts every result from its own copy of the limits and the code table, and compares.
// Depends on dvst_pkg.

module dvst_level_checker
   import dvst_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_type,
   input  logic [LEVEL_W-1:0]    req_level,
   input  logic [UV_W-1:0]       req_target_microvolts,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [VOUT_W-1:0]     rsp_voltage_uv,
   input  logic [CODE_W-1:0]     rsp_voltage_code,
   output int                    pending_results,
   output int                    failures
);

   typedef struct packed {
      status_type          status;
      logic [VOUT_W-1:0]   voltage_uv;
      logic [CODE_W-1:0]   code;
   } level_result_t;

   // Private copy of the limit registers and of the code table.
   logic [UV_W-1:0]     lim_min_uv;
   logic [UV_W-1:0]     lim_mid_uv;
   logic [UV_W-1:0]     lim_max_uv;
   logic [FINE_W-1:0]   fine_step_uv;
   logic [COARSE_W-1:0] coarse_step_uv;
   logic [CODE_W-1:0]   mid_code;
   logic [COUNT_W-1:0]  level_count;
   logic [CODE_W-1:0]   stored_codes [LEVELS];

   level_result_t expected_results [$];
   level_result_t want;

   // Two-segment mapping from microvolts to a code, saturating at the top code.
   function automatic logic [CODE_W-1:0] uv_to_code(input longint unsigned uv);
      longint unsigned q;
      if (uv >= lim_mid_uv) begin
         if (coarse_step_uv == 0)
            q = 64'(CODE_MAX);
         else
            q = (uv - lim_mid_uv) / coarse_step_uv + mid_code;
      end else if (uv >= lim_min_uv) begin
         if (fine_step_uv == 0)
            q = 64'(CODE_MAX);
         else
            q = (uv - lim_min_uv) / fine_step_uv;
      end else begin
         q = 0;
      end
      if (q > CODE_MAX)
         q = 64'(CODE_MAX);
      return q[CODE_W-1:0];
   endfunction

   // Readback of a code at full width, before any limit check.
   function automatic longint unsigned code_to_uv(input logic [CODE_W-1:0] code);
      longint unsigned c;
      c = 64'(code);
      if (code >= mid_code)
         return (c - mid_code) * coarse_step_uv + lim_mid_uv;
      return c * fine_step_uv + lim_min_uv;
   endfunction

   // Result of one request against the current limits and table.
   function automatic level_result_t predict_level_result(input logic kind,
                                                          input logic [LEVEL_W-1:0] lvl,
                                                          input logic [UV_W-1:0] target);
      level_result_t r;
      longint unsigned uv;
      longint unsigned volt;
      logic level_ok;
      r.status = STATUS_OK;
      r.voltage_uv = '0;
      r.code = '0;
      uv = 64'(target);
      level_ok = (lvl < level_count) && (lvl < LEVELS);
      if (kind == REQ_SET) begin
         // The voltage is checked before the level.
         if (uv < lim_min_uv || uv > lim_max_uv)
            r.status = STATUS_REQ_VOLT;
         else if (!level_ok)
            r.status = STATUS_LEVEL_BAD;
         else
            r.code = uv_to_code(uv);
      end else if (!level_ok) begin
         r.status = STATUS_LEVEL_BAD;
      end else begin
         r.code = stored_codes[lvl];
         volt = code_to_uv(r.code);
         if (volt < lim_min_uv || volt > lim_max_uv) begin
            r.status = STATUS_STORED_VOLT;
            volt = 64'(lim_min_uv);
         end
         r.voltage_uv = volt[VOUT_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lim_min_uv = MIN_UV_RST;
         lim_mid_uv = MID_UV_RST;
         lim_max_uv = MAX_UV_RST;
         fine_step_uv = FINE_STEP_RST;
         coarse_step_uv = COARSE_STEP_RST;
         mid_code = MID_CODE_RST;
         level_count = LEVEL_COUNT_RST;
         foreach (stored_codes[i])
            stored_codes[i] = '0;
         expected_results.delete();
         pending_results = 0;
         failures = 0;
      end else begin
         // Register writes, cut to each register's width.
         if (csr_wr_en) begin
            case (csr_index)
               REG_MIN_UV:      lim_min_uv = csr_wr_data[UV_W-1:0];
               REG_MID_UV:      lim_mid_uv = csr_wr_data[UV_W-1:0];
               REG_MAX_UV:      lim_max_uv = csr_wr_data[UV_W-1:0];
               REG_FINE_STEP:   fine_step_uv = csr_wr_data[FINE_W-1:0];
               REG_COARSE_STEP: coarse_step_uv = csr_wr_data[COARSE_W-1:0];
               REG_MID_CODE:    mid_code = csr_wr_data[CODE_W-1:0];
               REG_LEVEL_COUNT: level_count = csr_wr_data[COUNT_W-1:0];
               default: ;
            endcase
         end

         // Compare an accepted result with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected: status %0d uv %0d code %0d",
                        $time, rsp_status, rsp_voltage_uv, rsp_voltage_code);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
                  failures++;
               end
               if (rsp_voltage_uv !== want.voltage_uv) begin
                  $display("%0t: voltage_uv expected %0d, got %0d",
                           $time, want.voltage_uv, rsp_voltage_uv);
                  failures++;
               end
               if (rsp_voltage_code !== want.code) begin
                  $display("%0t: voltage_code expected %0d, got %0d",
                           $time, want.code, rsp_voltage_code);
                  failures++;
               end
            end
         end

         // Predict an accepted item; a good set updates the table.
         if (req_valid && !req_stall) begin
            want = predict_level_result(req_type, req_level, req_target_microvolts);
            expected_results.push_back(want);
            if (req_type == REQ_SET && want.status == STATUS_OK)
               stored_codes[req_level] = want.code;
         end
         pending_results = expected_results.size();
      end
   end

endmodule

// ===== sim/tb_dvc_voltage_set_table_top.sv =====
// Testbench top for the voltage level table: clock, reset, register setup and item stimulus
// with random idling on both channels; the verdict comes from dvst_level_checker.
// Depends on dvst_pkg, dvc_voltage_set_table_top and dvst_level_checker.

module tb_dvc_voltage_set_table_top;
   import dvst_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_ITEMS = 250;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [LEVEL_W-1:0]    req_level;
   logic [UV_W-1:0]       req_target_microvolts;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [VOUT_W-1:0]     rsp_voltage_uv;
   logic [CODE_W-1:0]     rsp_voltage_code;

   int pending_results;
   int failures;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   logic hold_for_drain;

   // Limits as last written, used to aim the stimulus.
   logic [UV_W-1:0]    cfg_min_uv;
   logic [UV_W-1:0]    cfg_mid_uv;
   logic [UV_W-1:0]    cfg_max_uv;
   logic [COUNT_W-1:0] cfg_level_count;

   dvc_voltage_set_table_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_level             (req_level),
      .req_target_microvolts (req_target_microvolts),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_voltage_uv        (rsp_voltage_uv),
      .rsp_voltage_code      (rsp_voltage_code)
   );

   dvst_level_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_level             (req_level),
      .req_target_microvolts (req_target_microvolts),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_voltage_uv        (rsp_voltage_uv),
      .rsp_voltage_code      (rsp_voltage_code),
      .pending_results       (pending_results),
      .failures              (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register write; the enable drops again at the next falling edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[CSR_DATA_W-1:0];
      case (idx)
         REG_MIN_UV:      cfg_min_uv = value[UV_W-1:0];
         REG_MID_UV:      cfg_mid_uv = value[UV_W-1:0];
         REG_MAX_UV:      cfg_max_uv = value[UV_W-1:0];
         REG_LEVEL_COUNT: cfg_level_count = value[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_limits(input int unsigned min_uv, input int unsigned mid_uv,
                                 input int unsigned max_uv, input int unsigned fine,
                                 input int unsigned coarse, input int unsigned code,
                                 input int unsigned count);
      write_reg(REG_MIN_UV, min_uv);
      write_reg(REG_MID_UV, mid_uv);
      write_reg(REG_MAX_UV, max_uv);
      write_reg(REG_FINE_STEP, fine);
      write_reg(REG_COARSE_STEP, coarse);
      write_reg(REG_MID_CODE, code);
      write_reg(REG_LEVEL_COUNT, count);
   endtask

   // Lowers valid and waits until every expected result has come, then lets the block settle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offers one item, after a random gap or a full drain, and returns once it is accepted.
   task automatic send_item(input logic kind, input logic [LEVEL_W-1:0] lvl,
                            input logic [UV_W-1:0] uv);
      @(negedge clock);
      while ((hold_for_drain && pending_results != 0) ||
             $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      hold_for_drain = 1'b0;
      req_valid <= 1'b1;
      req_type <= kind;
      req_level <= lvl;
      req_target_microvolts <= uv;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   initial begin
      int phase;
      int unsigned p_min;
      int unsigned p_mid;
      int unsigned p_max;
      int unsigned p_fine;
      int unsigned p_coarse;
      int unsigned p_code;
      int unsigned p_count;
      int unsigned usable;
      logic kind;
      logic [LEVEL_W-1:0] lvl;
      logic [UV_W-1:0] uv;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_type = REQ_SET;
      req_level = '0;
      req_target_microvolts = '0;
      rsp_stall = 1'b0;
      quiet_cycles = 0;
      hold_for_drain = 1'b0;
      send_idle_pct = 33;
      recv_stall_pct = 88;
      cfg_min_uv = MIN_UV_RST;
      cfg_mid_uv = MID_UV_RST;
      cfg_max_uv = MAX_UV_RST;
      cfg_level_count = LEVEL_COUNT_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset limits: unwritten entry, both voltage bounds,
      // both segments and the mid point, and voltages rejected at the field extremes.
      send_item(REQ_GET, 4'd0, 22'd0);
      send_item(REQ_SET, 4'd0, 22'd599999);
      send_item(REQ_SET, 4'd15, 22'd1800001);
      send_item(REQ_SET, 4'd0, 22'd600000);
      send_item(REQ_SET, 4'd15, 22'd1800000);
      send_item(REQ_SET, 4'd3, 22'd1599999);
      send_item(REQ_SET, 4'd4, 22'd1600000);
      send_item(REQ_GET, 4'd15, 22'h3fffff);
      send_item(REQ_GET, 4'd3, 22'd0);
      send_item(REQ_GET, 4'd4, 22'd0);
      send_item(REQ_SET, 4'd7, 22'd0);
      send_item(REQ_SET, 4'd9, 22'h3fffff);

      // A lower maximum turns a stored code into a readback out of range.
      drain_results();
      write_reg(REG_MAX_UV, 1700000);
      send_item(REQ_GET, 4'd15, 22'd0);
      send_item(REQ_GET, 4'd0, 22'd0);

      // Fewer usable levels; a bad voltage is reported ahead of a bad level.
      drain_results();
      write_reg(REG_LEVEL_COUNT, 5);
      send_item(REQ_SET, 4'd5, 22'd1000000);
      send_item(REQ_SET, 4'd9, 22'd100);
      send_item(REQ_GET, 4'd5, 22'd0);
      send_item(REQ_GET, 4'd4, 22'd0);

      // A level count of zero rejects every level.
      drain_results();
      write_reg(REG_LEVEL_COUNT, 0);
      send_item(REQ_GET, 4'd0, 22'd0);
      send_item(REQ_SET, 4'd0, 22'd1000000);

      // Zero steps saturate the code in both segments.
      drain_results();
      write_reg(REG_FINE_STEP, 0);
      write_reg(REG_COARSE_STEP, 0);
      write_reg(REG_LEVEL_COUNT, 16);
      send_item(REQ_SET, 4'd1, 22'd700000);
      send_item(REQ_SET, 4'd2, 22'd1650000);
      send_item(REQ_GET, 4'd1, 22'd0);

      // Minimum above maximum rejects every set.
      drain_results();
      write_reg(REG_MIN_UV, 1800000);
      send_item(REQ_SET, 4'd2, 22'd1750000);
      send_item(REQ_SET, 4'd2, 22'd1700000);

      // Random part: one limit setting per phase, idling mode changing over the run.
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               p_min = 32'(MIN_UV_RST); p_mid = 32'(MID_UV_RST); p_max = 32'(MAX_UV_RST);
               p_fine = 32'(FINE_STEP_RST); p_coarse = 32'(COARSE_STEP_RST);
               p_code = 32'(MID_CODE_RST); p_count = 32'(LEVEL_COUNT_RST);
            end
            1: begin
               p_min = 0; p_mid = 2000000; p_max = 32'h3fffff;
               p_fine = 1; p_coarse = 1; p_code = 0; p_count = 31;
            end
            2: begin
               p_min = 1000000; p_mid = 1000000; p_max = 3000000;
               p_fine = 100000; p_coarse = 200000; p_code = 127; p_count = 8;
            end
            3: begin
               p_min = 300000; p_mid = 2500000; p_max = 4000000;
               p_fine = 0; p_coarse = 0; p_code = 64; p_count = 1;
            end
            4: begin
               p_min = $urandom_range(0, 2000000);
               p_mid = $urandom_range(p_min, 4000000);
               p_max = $urandom_range(p_mid, 4000000);
               p_fine = $urandom_range(1, 100000);
               p_coarse = $urandom_range(1, 200000);
               p_code = $urandom_range(0, 127);
               p_count = $urandom_range(1, 16);
            end
            5: begin
               p_min = $urandom & 32'h3fffff;
               p_mid = $urandom & 32'h3fffff;
               p_max = $urandom & 32'h3fffff;
               p_fine = $urandom & 32'h1ffff;
               p_coarse = $urandom & 32'h3ffff;
               p_code = $urandom & 32'h7f;
               p_count = $urandom & 32'h1f;
            end
            6: begin
               p_min = 32'h3fffff; p_mid = 32'h3fffff; p_max = 32'h3fffff;
               p_fine = 32'h1ffff; p_coarse = 32'h3ffff; p_code = 127; p_count = 16;
            end
            default: begin
               p_min = $urandom_range(0, 1000000);
               p_mid = $urandom_range(p_min, 2500000);
               p_max = $urandom_range(p_mid, 4000000);
               p_fine = $urandom_range(1, 30000);
               p_coarse = $urandom_range(1, 80000);
               p_code = $urandom_range(0, 127);
               p_count = $urandom_range(1, 16);
            end
         endcase

         if (phase < 3) begin
            send_idle_pct = 33;
            recv_stall_pct = 88;
         end else if (phase < 6) begin
            send_idle_pct = 88;
            recv_stall_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end

         drain_results();
         program_limits(p_min, p_mid, p_max, p_fine, p_coarse, p_code, p_count);

         repeat (PHASE_ITEMS) begin
            // Mostly usable levels and voltages inside the limits, so sets and later
            // gets of the same level meet; the rest hits the edges or is pure noise.
            kind = 1'($urandom_range(0, 1));
            usable = (cfg_level_count == 0 || cfg_level_count > 16) ? 16 : cfg_level_count;
            if ($urandom_range(0, 99) < 85)
               lvl = LEVEL_W'($urandom_range(0, usable - 1));
            else
               lvl = LEVEL_W'($urandom_range(0, 15));
            p_fine = $urandom_range(0, 99);
            if (p_fine < 65 && cfg_min_uv <= cfg_max_uv) begin
               uv = UV_W'($urandom_range(cfg_min_uv, cfg_max_uv));
            end else if (p_fine < 82) begin
               case ($urandom_range(0, 6))
                  0: uv = cfg_min_uv;
                  1: uv = cfg_min_uv - 1'b1;
                  2: uv = cfg_max_uv;
                  3: uv = cfg_max_uv + 1'b1;
                  4: uv = cfg_mid_uv;
                  5: uv = cfg_mid_uv - 1'b1;
                  default: uv = cfg_mid_uv + 1'b1;
               endcase
            end else begin
               uv = UV_W'($urandom);
            end
            if ($urandom_range(0, 63) == 0)
               hold_for_drain = 1'b1;
            send_item(kind, lvl, uv);
         end
      end

      drain_results();
      if (failures == 0 && pending_results == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dvst_pkg.sv
rtl/dvst_ram.sv
rtl/dvst_ctrl.sv
rtl/dvst_dp.sv
rtl/dvc_voltage_set_table_top.sv
sim/dvst_level_checker.sv
sim/tb_dvc_voltage_set_table_top.sv
